FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/shah_pkg.sv
// ----------------------------------------------------------------------------
// SPI host attention handshake package
// Word types, register indexes, reset values and sequencer phase codes.
// ----------------------------------------------------------------------------
package shah_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CNT_W      = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_BIT    = 3'd0,
		REG_SETUP       = 3'd1,
		REG_BYTE_GAP    = 3'd2,
		REG_PACKET_GAP  = 3'd3,
		REG_RX_EXTRA    = 3'd4,
		REG_ATN_TIMEOUT = 3'd5
	} reg_index_t;

	localparam logic [15:0]      RST_HALF_BIT    = 16'd2;
	localparam logic [15:0]      RST_SETUP       = 16'd100;
	localparam logic [15:0]      RST_BYTE_GAP    = 16'd150;
	localparam logic [15:0]      RST_PACKET_GAP  = 16'd120;
	localparam logic [15:0]      RST_RX_EXTRA    = 16'd100;
	localparam logic [CNT_W-1:0] RST_ATN_TIMEOUT = 24'd10000;

	typedef enum logic [10:0] {
		PH_IDLE      = 11'b000_0000_0001,
		PH_TX_ATN    = 11'b000_0000_0010,
		PH_SETUP     = 11'b000_0000_0100,
		PH_LOW       = 11'b000_0000_1000,
		PH_HIGH      = 11'b000_0001_0000,
		PH_RX_EXTRA  = 11'b000_0010_0000,
		PH_GAP       = 11'b000_0100_0000,
		PH_WAIT_BYTE = 11'b000_1000_0000,
		PH_DROP      = 11'b001_0000_0000,
		PH_GUARD     = 11'b010_0000_0000,
		PH_RX_ATN    = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       cmd_receive;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       attention_asserted;
		logic       miso_level;
	} tick_word_t;

	typedef struct packed {
		logic       select_active;
		logic       sclk_level;
		logic       mosi_level;
		logic       host_active;
		logic       ready_for_byte;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       packet_done;
		logic       timeout_error;
		logic       busy_res;
	} status_word_t;

endpackage

FILE: sv/spi_host_attention_handshake.sv
// ----------------------------------------------------------------------------
// SPI host with attention handshake
// Drives select, clock and data toward a slave that paces transfers with an
// attention line; sends and receives words of BITS_PER_WORD bits.
// ----------------------------------------------------------------------------
// Each input word is one time tick holding the sampled attention and MISO
// lines and an optional command. The block takes one word every clock cycle
// and returns exactly one status word per tick in the next cycle, from its
// result register. The sequencer state is updated in a single pass of logic
// per tick, so throughput is one tick per cycle; it stalls the input side only
// while the result register is full and the downstream side stalls. Timing
// registers are counted in ticks, not clock cycles.
module spi_host_attention_handshake
	import shah_pkg::*;
#(
	parameter int BITS_PER_WORD = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  tick_word_t            item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output status_word_t          result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	`include "assert_macros.svh"

	localparam int W   = BITS_PER_WORD;
	localparam int BCW = $clog2(BITS_PER_WORD + 1);

	// Configuration registers.
	logic [15:0]      half_bit_q, setup_q, byte_gap_q, packet_gap_q, rx_extra_q;
	logic [CNT_W-1:0] timeout_q;

	// Sequencer state.
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] wait_q, wait_d, cnt_inc, target;
	logic [BCW-1:0]   bit_cnt_q, bit_cnt_d, bit_dec;
	logic [W-1:0]     shift_q, shift_d, tx_word;
	logic             last_q, last_d, dir_rx_q, dir_rx_d;
	logic             sel_q, sel_d, sclk_q, sclk_d, mosi_q, mosi_d;
	logic             timed_hit, rxv, done, terr;
	logic [7:0]       rxd, rx_byte;

	logic         acc;
	logic         result_valid_q;
	status_word_t result_q;

	assign acc          = item_valid && !item_stall;
	assign item_stall   = result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Fit the 8-bit transmit byte to the word width, and the word back to 8 bits.
	for (genvar i = 0; i < W; i++) begin : g_tx
		if (i < 8) begin : g_bit
			assign tx_word[i] = item.tx_byte[i];
		end else begin : g_zero
			assign tx_word[i] = 1'b0;
		end
	end
	for (genvar i = 0; i < 8; i++) begin : g_rx
		if (i < W) begin : g_bit
			assign rx_byte[i] = shift_q[i];
		end else begin : g_zero
			assign rx_byte[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q   <= RST_HALF_BIT;
			setup_q      <= RST_SETUP;
			byte_gap_q   <= RST_BYTE_GAP;
			packet_gap_q <= RST_PACKET_GAP;
			rx_extra_q   <= RST_RX_EXTRA;
			timeout_q    <= RST_ATN_TIMEOUT;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_HALF_BIT:    half_bit_q   <= wr_data[15:0];
				REG_SETUP:       setup_q      <= wr_data[15:0];
				REG_BYTE_GAP:    byte_gap_q   <= wr_data[15:0];
				REG_PACKET_GAP:  packet_gap_q <= wr_data[15:0];
				REG_RX_EXTRA:    rx_extra_q   <= wr_data[15:0];
				REG_ATN_TIMEOUT: timeout_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// Target of the timed wait that the current phase runs.
	always_comb begin
		case (phase_q)
			PH_TX_ATN, PH_RX_ATN, PH_DROP: target = timeout_q;
			PH_SETUP:                      target = {8'd0, setup_q};
			PH_LOW, PH_HIGH:               target = {8'd0, half_bit_q};
			PH_RX_EXTRA:                   target = {8'd0, rx_extra_q};
			PH_GAP:                        target = {8'd0, byte_gap_q};
			PH_GUARD:                      target = {8'd0, packet_gap_q};
			default:                       target = '0;
		endcase
	end

	assign cnt_inc   = wait_q + 1'b1;
	assign timed_hit = cnt_inc >= target;
	assign bit_dec   = (bit_cnt_q != '0) ? bit_cnt_q - 1'b1 : '0;

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		last_d    = last_q;
		dir_rx_d  = dir_rx_q;
		sel_d     = sel_q;
		sclk_d    = sclk_q;
		mosi_d    = mosi_q;
		rxv       = 1'b0;
		rxd       = 8'd0;
		done      = 1'b0;
		terr      = 1'b0;

		case (phase_q)
			PH_TX_ATN, PH_RX_ATN: begin
				if (item.attention_asserted) begin
					sel_d   = 1'b1;
					phase_d = PH_SETUP;
					wait_d  = '0;
				end else begin
					wait_d = cnt_inc;
					if (timed_hit) begin
						terr    = 1'b1;
						sel_d   = 1'b0;
						phase_d = PH_IDLE;
						wait_d  = '0;
					end
				end
			end
			PH_SETUP: begin
				wait_d = cnt_inc;
				if (timed_hit) begin
					wait_d = '0;
					if (dir_rx_q && !item.attention_asserted) begin
						sel_d   = 1'b0;
						phase_d = PH_GUARD;
					end else begin
						if (dir_rx_q) begin
							shift_d = '0;
						end
						bit_cnt_d = BCW'(BITS_PER_WORD);
						sclk_d    = 1'b0;
						if (!dir_rx_q) begin
							mosi_d = shift_d[W-1];
						end
						phase_d = PH_LOW;
					end
				end
			end
			PH_LOW: begin
				wait_d = cnt_inc;
				if (timed_hit) begin
					sclk_d  = 1'b1;
					phase_d = PH_HIGH;
					wait_d  = '0;
				end
			end
			PH_HIGH, PH_RX_EXTRA: begin
				wait_d = cnt_inc;
				if (timed_hit) begin
					wait_d = '0;
					if (phase_q == PH_HIGH && dir_rx_q) begin
						// Sample MISO on the last tick of the clock high half.
						shift_d = (shift_q << 1) | W'(item.miso_level);
						phase_d = PH_RX_EXTRA;
					end else begin
						if (!dir_rx_q) begin
							shift_d = shift_q << 1;
						end
						bit_cnt_d = bit_dec;
						if (bit_dec != '0) begin
							sclk_d = 1'b0;
							if (!dir_rx_q) begin
								mosi_d = shift_d[W-1];
							end
							phase_d = PH_LOW;
						end else begin
							phase_d = PH_GAP;
						end
					end
				end
			end
			PH_GAP: begin
				wait_d = cnt_inc;
				if (timed_hit) begin
					wait_d = '0;
					if (dir_rx_q) begin
						rxv = 1'b1;
						rxd = rx_byte;
						if (item.attention_asserted) begin
							shift_d   = '0;
							bit_cnt_d = BCW'(BITS_PER_WORD);
							sclk_d    = 1'b0;
							phase_d   = PH_LOW;
						end else begin
							sel_d   = 1'b0;
							phase_d = PH_GUARD;
						end
					end else if (last_q) begin
						sel_d   = 1'b0;
						phase_d = PH_DROP;
					end else begin
						phase_d = PH_WAIT_BYTE;
					end
				end
			end
			PH_WAIT_BYTE: begin
				// No timeout here: the host holds until the next send word.
				if (item.cmd_valid && !item.cmd_receive) begin
					shift_d   = tx_word;
					last_d    = item.tx_last;
					bit_cnt_d = BCW'(BITS_PER_WORD);
					sclk_d    = 1'b0;
					mosi_d    = tx_word[W-1];
					phase_d   = PH_LOW;
					wait_d    = '0;
				end
			end
			PH_DROP: begin
				if (!item.attention_asserted) begin
					phase_d = PH_GUARD;
					wait_d  = '0;
				end else begin
					wait_d = cnt_inc;
					if (timed_hit) begin
						terr    = 1'b1;
						phase_d = PH_IDLE;
						wait_d  = '0;
					end
				end
			end
			PH_GUARD: begin
				wait_d = cnt_inc;
				if (timed_hit) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
					wait_d  = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.cmd_valid) begin
					wait_d = '0;
					if (item.cmd_receive) begin
						dir_rx_d = 1'b1;
						phase_d  = PH_RX_ATN;
					end else begin
						dir_rx_d = 1'b0;
						shift_d  = tx_word;
						last_d   = item.tx_last;
						sel_d    = 1'b1;
						phase_d  = PH_TX_ATN;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wait_q    <= '0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			last_q    <= 1'b0;
			dir_rx_q  <= 1'b0;
			sel_q     <= 1'b0;
			sclk_q    <= 1'b1;
			mosi_q    <= 1'b1;
		end else if (acc) begin
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			last_q    <= last_d;
			dir_rx_q  <= dir_rx_d;
			sel_q     <= sel_d;
			sclk_q    <= sclk_d;
			mosi_q    <= mosi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (acc) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			result_q.select_active  <= sel_d;
			result_q.sclk_level     <= sclk_d;
			result_q.mosi_level     <= mosi_d;
			result_q.host_active    <= 1'b1;
			result_q.ready_for_byte <= (phase_d == PH_IDLE) || (phase_d == PH_WAIT_BYTE);
			result_q.rx_valid       <= rxv;
			result_q.rx_data        <= rxd;
			result_q.packet_done    <= done;
			result_q.timeout_error  <= terr;
			result_q.busy_res       <= phase_d != PH_IDLE;
		end
	end

	`ASSERT_NEXT(a_accept_gives_result, acc, result_valid)
	`ASSERT_NEXT(a_timeout_only_in_wait, acc && !(phase_q == PH_TX_ATN ||
		phase_q == PH_RX_ATN || phase_q == PH_DROP), !result.timeout_error)
	`ASSERT_NEXT(a_rx_word_only_after_gap, acc && !(phase_q == PH_GAP && dir_rx_q),
		!result.rx_valid)
	`ASSERT_SAME(a_idle_select_off, phase_q == PH_IDLE, !sel_q)

endmodule

FILE: tb/spi_host_attention_handshake_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI host attention handshake testbench
// Feeds tick words built from attention runs, random MISO levels and random
// commands, predicts every status word in step with the accepted ticks, and
// compares each returned word field by field under random backpressure.
// ----------------------------------------------------------------------------
module spi_host_attention_handshake_test;
	import shah_pkg::*;

	localparam int WORD_BITS = 8;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_WORDS = 300;
	localparam realtime RUN_LIMIT = 3ms;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	tick_word_t            item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	status_word_t          result;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	spi_host_attention_handshake #(
		.BITS_PER_WORD(WORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ticks still to be offered, and status words still to come back.
	tick_word_t   tick_queue[$];
	status_word_t status_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;

	// Attention run generator state.
	bit atn_level = 1'b0;
	int atn_run = 0;

	// Sequencer copy.
	phase_t          seq_phase;
	logic [CNT_W-1:0] seq_wait;
	logic [3:0]      seq_bits;
	logic [7:0]      seq_shift;
	logic            seq_last;
	logic            seq_rx;
	logic            pin_sel;
	logic            pin_clk;
	logic            pin_mosi;

	// Timing register copy.
	logic [15:0]      cfg_half;
	logic [15:0]      cfg_setup;
	logic [15:0]      cfg_byte_gap;
	logic [15:0]      cfg_packet_gap;
	logic [15:0]      cfg_rx_extra;
	logic [CNT_W-1:0] cfg_timeout;

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic void enter_phase(phase_t p);
		seq_phase = p;
		seq_wait = '0;
	endfunction

	// Counts one tick of a timed wait; a zero target still costs one tick.
	function automatic bit count_reached(logic [CNT_W-1:0] target);
		seq_wait = seq_wait + 1'b1;
		return seq_wait >= target;
	endfunction

	function automatic void begin_bit();
		pin_clk = 1'b0;
		if (!seq_rx)
			pin_mosi = seq_shift[WORD_BITS-1];
		enter_phase(PH_LOW);
	endfunction

	function automatic void begin_word();
		seq_bits = 4'(WORD_BITS);
		begin_bit();
	endfunction

	function automatic void finish_bit();
		if (!seq_rx)
			seq_shift = seq_shift << 1;
		if (seq_bits > 0)
			seq_bits = seq_bits - 1'b1;
		if (seq_bits > 0)
			begin_bit();
		else
			enter_phase(PH_GAP);
	endfunction

	// Before each received word, attention decides between another word and
	// the end of the packet.
	function automatic void rx_word_check(logic atn);
		if (atn) begin
			seq_shift = '0;
			begin_word();
		end else begin
			pin_sel = 1'b0;
			enter_phase(PH_GUARD);
		end
	endfunction

	function automatic status_word_t advance_sequencer(tick_word_t t);
		status_word_t s;
		s = '0;
		case (seq_phase)
			PH_TX_ATN, PH_RX_ATN: begin
				if (t.attention_asserted) begin
					pin_sel = 1'b1;
					enter_phase(PH_SETUP);
				end else if (count_reached(cfg_timeout)) begin
					s.timeout_error = 1'b1;
					pin_sel = 1'b0;
					enter_phase(PH_IDLE);
				end
			end
			PH_SETUP: begin
				if (count_reached({8'd0, cfg_setup})) begin
					if (seq_rx)
						rx_word_check(t.attention_asserted);
					else
						begin_word();
				end
			end
			PH_LOW: begin
				if (count_reached({8'd0, cfg_half})) begin
					pin_clk = 1'b1;
					enter_phase(PH_HIGH);
				end
			end
			PH_HIGH: begin
				if (count_reached({8'd0, cfg_half})) begin
					if (seq_rx) begin
						seq_shift = {seq_shift[WORD_BITS-2:0], t.miso_level};
						enter_phase(PH_RX_EXTRA);
					end else begin
						finish_bit();
					end
				end
			end
			PH_RX_EXTRA: begin
				if (count_reached({8'd0, cfg_rx_extra}))
					finish_bit();
			end
			PH_GAP: begin
				if (count_reached({8'd0, cfg_byte_gap})) begin
					if (seq_rx) begin
						s.rx_valid = 1'b1;
						s.rx_data = seq_shift;
						rx_word_check(t.attention_asserted);
					end else if (seq_last) begin
						pin_sel = 1'b0;
						enter_phase(PH_DROP);
					end else begin
						enter_phase(PH_WAIT_BYTE);
					end
				end
			end
			PH_WAIT_BYTE: begin
				if (t.cmd_valid && !t.cmd_receive) begin
					seq_shift = t.tx_byte;
					seq_last = t.tx_last;
					begin_word();
				end
			end
			PH_DROP: begin
				if (!t.attention_asserted) begin
					enter_phase(PH_GUARD);
				end else if (count_reached(cfg_timeout)) begin
					s.timeout_error = 1'b1;
					enter_phase(PH_IDLE);
				end
			end
			PH_GUARD: begin
				if (count_reached({8'd0, cfg_packet_gap})) begin
					s.packet_done = 1'b1;
					enter_phase(PH_IDLE);
				end
			end
			default: begin
				seq_phase = PH_IDLE;
				if (t.cmd_valid) begin
					if (t.cmd_receive) begin
						seq_rx = 1'b1;
						enter_phase(PH_RX_ATN);
					end else begin
						seq_rx = 1'b0;
						seq_shift = t.tx_byte;
						seq_last = t.tx_last;
						pin_sel = 1'b1;
						enter_phase(PH_TX_ATN);
					end
				end
			end
		endcase
		s.select_active = pin_sel;
		s.sclk_level = pin_clk;
		s.mosi_level = pin_mosi;
		s.host_active = 1'b1;
		s.ready_for_byte = (seq_phase == PH_IDLE) || (seq_phase == PH_WAIT_BYTE);
		s.busy_res = (seq_phase != PH_IDLE);
		return s;
	endfunction

	// Sender: offers queued ticks, holds a stalled word, predicts on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				status_due.push_back(advance_sequencer(item));
			if (!item_valid || !item_stall) begin
				if (tick_queue.size() != 0 && !roll(send_idle_pct)) begin
					item <= tick_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	int words_seen = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	// Receiver: checks every accepted status word and applies backpressure,
	// including one long hold-off that fills the block and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		status_word_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				words_seen++;
				if (status_due.size() == 0) begin
					$error("status word with nothing outstanding: %h", result);
					errors++;
				end else begin
					want = status_due.pop_front();
					check_field("select_active", 8'(want.select_active),
						8'(result.select_active));
					check_field("sclk_level", 8'(want.sclk_level), 8'(result.sclk_level));
					check_field("mosi_level", 8'(want.mosi_level), 8'(result.mosi_level));
					check_field("host_active", 8'(want.host_active),
						8'(result.host_active));
					check_field("ready_for_byte", 8'(want.ready_for_byte),
						8'(result.ready_for_byte));
					check_field("rx_valid", 8'(want.rx_valid), 8'(result.rx_valid));
					check_field("rx_data", want.rx_data, result.rx_data);
					check_field("packet_done", 8'(want.packet_done),
						8'(result.packet_done));
					check_field("timeout_error", 8'(want.timeout_error),
						8'(result.timeout_error));
					check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (!held_once && words_seen >= HOLD_AFTER_WORDS) begin
				held_once <= 1'b1;
				hold_left <= LONG_HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= roll(recv_idle_pct);
			end
		end
	end

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_HALF_BIT:    cfg_half = value[15:0];
			REG_SETUP:       cfg_setup = value[15:0];
			REG_BYTE_GAP:    cfg_byte_gap = value[15:0];
			REG_PACKET_GAP:  cfg_packet_gap = value[15:0];
			REG_RX_EXTRA:    cfg_rx_extra = value[15:0];
			REG_ATN_TIMEOUT: cfg_timeout = value;
			default: ;
		endcase
	endtask

	task automatic set_timing(int half, int setup, int byte_gap, int packet_gap, int rx_extra,
			int timeout);
		write_reg(REG_HALF_BIT, CFG_DATA_W'(half));
		write_reg(REG_SETUP, CFG_DATA_W'(setup));
		write_reg(REG_BYTE_GAP, CFG_DATA_W'(byte_gap));
		write_reg(REG_PACKET_GAP, CFG_DATA_W'(packet_gap));
		write_reg(REG_RX_EXTRA, CFG_DATA_W'(rx_extra));
		write_reg(REG_ATN_TIMEOUT, CFG_DATA_W'(timeout));
	endtask

	task automatic add_ticks(bit cmd, bit rx, logic [7:0] tx, bit last, bit atn, bit miso,
			int reps);
		tick_word_t t;
		t.cmd_valid = cmd;
		t.cmd_receive = rx;
		t.tx_byte = tx;
		t.tx_last = last;
		t.attention_asserted = atn;
		t.miso_level = miso;
		repeat (reps) tick_queue.push_back(t);
	endtask

	// Attention comes in runs so that transfers get deep; commands are
	// sprinkled at random and land in every phase.
	task automatic add_random_ticks(int count);
		tick_word_t t;
		for (int i = 0; i < count; i++) begin
			if (atn_run == 0) begin
				atn_level = !atn_level;
				atn_run = atn_level ? $urandom_range(150, 1) : $urandom_range(60, 1);
			end
			atn_run--;
			t.cmd_valid = ($urandom_range(7) == 0);
			t.cmd_receive = 1'($urandom_range(1));
			t.tx_byte = 8'($urandom_range(255));
			t.tx_last = ($urandom_range(2) == 0);
			t.attention_asserted = atn_level;
			t.miso_level = 1'($urandom_range(1));
			tick_queue.push_back(t);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (tick_queue.size() != 0 || item_valid || status_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_phase(int count);
		@(negedge clk);
		add_random_ticks(count);
		wait_drained();
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		seq_phase = PH_IDLE;
		seq_wait = '0;
		seq_bits = '0;
		seq_shift = '0;
		seq_last = 1'b0;
		seq_rx = 1'b0;
		pin_sel = 1'b0;
		pin_clk = 1'b1;
		pin_mosi = 1'b1;
		cfg_half = RST_HALF_BIT;
		cfg_setup = RST_SETUP;
		cfg_byte_gap = RST_BYTE_GAP;
		cfg_packet_gap = RST_PACKET_GAP;
		cfg_rx_extra = RST_RX_EXTRA;
		cfg_timeout = RST_ATN_TIMEOUT;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// A few ticks under the reset timing first.
		send_idle_pct = 35;
		recv_idle_pct = 88;
		@(negedge clk);
		add_ticks(1'b1, 1'b0, 8'h5A, 1'b0, 1'b1, 1'b0, 6);
		wait_drained();

		// Shortest timing; the directed words run through every phase.
		set_timing(1, 0, 0, 0, 0, 1);
		@(negedge clk);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 20);
		wait_drained();
		set_timing(1, 0, 0, 0, 0, 3);
		@(negedge clk);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2);
		add_ticks(1'b1, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b1, 1);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 20);
		// A receive command while the next send word is awaited is ignored.
		add_ticks(1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1);
		add_ticks(1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 18);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3);
		add_ticks(1'b1, 1'b0, 8'h81, 1'b1, 1'b0, 1'b0, 1);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 19);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 3);
		// Receive without attention runs into the timeout.
		add_ticks(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 4);
		add_ticks(1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1);
		add_ticks(1'b1, 1'b0, 8'hAA, 1'b0, 1'b1, 1'b1, 28);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 28);
		add_ticks(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 4);
		wait_drained();

		random_phase(200);
		set_timing($urandom_range(3, 1), $urandom_range(6), $urandom_range(6),
			$urandom_range(6), $urandom_range(4), $urandom_range(40, 4));
		random_phase(280);

		send_idle_pct = 88;
		recv_idle_pct = 35;
		set_timing($urandom_range(2, 1), $urandom_range(3), $urandom_range(3),
			$urandom_range(3), $urandom_range(2), $urandom_range(60, 8));
		random_phase(280);
		// Longest timing: every wait is left running when the phase ends.
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		random_phase(120);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_timing(1, $urandom_range(2), $urandom_range(2), $urandom_range(2),
			$urandom_range(1), $urandom_range(30, 5));
		random_phase(160);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
